>>> hdl/packed_genotype_unpacker_macros.svh
// assertion helpers for the genotype unpacker
`ifndef PACKED_GENOTYPE_UNPACKER_MACROS_SVH
`define PACKED_GENOTYPE_UNPACKER_MACROS_SVH

// condition holds in the same cycle
`define PGU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define PGU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pgu_pkg.sv
`timescale 1ns / 1ps

package pgu_pkg;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_FORMAT  = 2'd0,
    REG_SAMPLES = 2'd1,
    REG_BYTES   = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  localparam logic [14:0] MAX_REC_BYTES = 15'd16384;
  localparam logic [15:0] CHUNK_MAX     = 16'hFFFF;
  localparam logic [1:0]  GENO_MISSING  = 2'd3;

  // genotypes of one byte waiting to be emitted
  typedef struct packed {
    logic [3:0]       geno_mask;
    logic             summary;
    logic [3:0][1:0]  geno;
    logic [15:0]      sample_base;
    logic [15:0]      chunk;
    logic [5:0]       bit_idx;
    logic [16:0]      allele;
    logic [15:0]      called;
  } batch_t;

  // one result word
  typedef struct packed {
    logic        kind;
    logic [15:0] sample;
    logic [15:0] chunk;
    logic [5:0]  bit_idx;
    logic [1:0]  geno;
    logic [16:0] allele;
    logic [15:0] called;
    logic        last;
  } result_t;

  // second format code remap
  function automatic logic [1:0] remap_code(input logic [1:0] raw);
    logic [1:0] g;
    unique case (raw)
      2'd0:    g = 2'd2;
      2'd1:    g = 2'd3;
      2'd2:    g = 2'd1;
      default: g = 2'd0;
    endcase
    return g;
  endfunction

  // chunk index step with saturation
  function automatic logic [15:0] chunk_step(input logic [15:0] c);
    return (c == CHUNK_MAX) ? c : c + 16'd1;
  endfunction

endpackage

>>> hdl/pgu_emit.sv
`timescale 1ns / 1ps

module pgu_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  pgu_pkg::batch_t  batch_i,
  output logic             take_o,
  output pgu_pkg::result_t result_o,
  output logic             out_valid_o,
  input  logic             out_ready_i
);

  logic [4:0]       rem_q, rem_d;
  pgu_pkg::batch_t  b_q;
  pgu_pkg::result_t out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic [2:0]       sel;
  logic [4:0]       sel_hot;
  logic [4:0]       rem_after;
  logic             move;

  // lowest pending result goes first
  always_comb begin
    sel     = 3'd0;
    sel_hot = 5'd0;
    for (int k = 4; k >= 0; k--) begin
      if (rem_q[k]) begin
        sel     = 3'(k);
        sel_hot = 5'(1) << k;
      end
    end
  end

  assign rem_after = rem_q & ~sel_hot;
  assign move      = (rem_q != 5'd0) && (!out_valid_q || out_ready_i);
  assign take_o    = (rem_q == 5'd0) || (move && (rem_after == 5'd0));

  // build the next result word
  always_comb begin
    out_d.chunk   = b_q.chunk;
    out_d.bit_idx = b_q.bit_idx;
    out_d.last    = (rem_after == 5'd0);
    if (sel[2]) begin
      out_d.kind   = 1'b1;
      out_d.sample = 16'd0;
      out_d.geno   = 2'd0;
      out_d.allele = b_q.allele;
      out_d.called = b_q.called;
    end else begin
      out_d.kind   = 1'b0;
      out_d.sample = b_q.sample_base + {14'd0, sel[1:0]};
      out_d.geno   = b_q.geno[sel[1:0]];
      out_d.allele = 17'd0;
      out_d.called = 16'd0;
    end
  end

  // pending mask and output valid
  always_comb begin
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    if (move) begin
      rem_d       = rem_after;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_i && take_o) begin
      rem_d = {batch_i.summary, batch_i.geno_mask};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_i && take_o) begin
      b_q <= batch_i;
    end
    if (move) begin
      out_q <= out_d;
    end
  end

  assign result_o    = out_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/packed_genotype_unpacker.sv
`timescale 1ns / 1ps
// the results of an accepted byte are held in the emitter's batch register and pending mask,
// then moved one at a time into its output register: one result word per cycle unless out_ready_i stalls it
// (up to four genotypes plus a summary per byte); a byte with no results loads nothing into the emitter
// the emitter's pending batch register sets the rate; a new byte enters as the last word leaves
// reset: asynchronous active low; registers back to format 1, one sample, one byte per record

`include "packed_genotype_unpacker_macros.svh"

module packed_genotype_unpacker #(
  parameter int CHUNK_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  packed_byte_i,
  input  logic        skip_marker_i,
  input  logic        chromosome_start_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [15:0] sample_index_o,
  output logic [15:0] chunk_index_o,
  output logic [5:0]  bit_index_o,
  output logic [1:0]  genotype_o,
  output logic [16:0] allele_count_o,
  output logic [15:0] called_count_o,
  output logic        last_o
);

  localparam logic [6:0] ChunkBitsW = 7'(CHUNK_BITS);

  logic        format_q;
  logic [15:0] samples_q;
  logic [14:0] rec_bytes_q;

  logic [13:0] byte_pos_q;
  logic [15:0] chunk_q;
  logic [5:0]  bit_q;
  logic [16:0] allele_q;
  logic [15:0] called_q;
  logic        skipping_q;

  logic              cfg_wr;
  pgu_pkg::reg_idx_e cfg_idx;
  logic              accept;
  logic [13:0]       len_m1;
  logic              end_rec;
  logic              first_byte;
  logic              skip_now;
  logic              bump_start;
  logic [15:0]       chunk_a;
  logic [5:0]        bit_a;
  logic [6:0]        bit_inc;
  logic [3:0]        add_allele;
  logic [2:0]        add_called;
  logic [16:0]       allele_new;
  logic [15:0]       called_new;
  pgu_pkg::batch_t   batch;
  logic              batch_load;
  logic              take;
  pgu_pkg::result_t  res;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = pgu_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q    <= 1'b1;
      samples_q   <= 16'd1;
      rec_bytes_q <= 15'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pgu_pkg::REG_FORMAT:  format_q    <= pwdata[0];
        pgu_pkg::REG_SAMPLES: samples_q   <= pwdata[15:0];
        pgu_pkg::REG_BYTES:   rec_bytes_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      pgu_pkg::REG_FORMAT:  prdata = {31'd0, format_q};
      pgu_pkg::REG_SAMPLES: prdata = {16'd0, samples_q};
      pgu_pkg::REG_BYTES:   prdata = {17'd0, rec_bytes_q};
      default:              prdata = 32'd0;
    endcase
  end

  // record position and marker flags
  always_comb begin
    if (rec_bytes_q == 15'd0) begin
      len_m1 = 14'd0;
    end else if (rec_bytes_q > pgu_pkg::MAX_REC_BYTES) begin
      len_m1 = 14'h3FFF;
    end else begin
      len_m1 = 14'(rec_bytes_q - 15'd1);
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign end_rec    = (byte_pos_q >= len_m1);
  assign first_byte = (byte_pos_q == 14'd0);
  assign skip_now   = first_byte ? skip_marker_i : skipping_q;
  assign bump_start = first_byte && !skip_marker_i && chromosome_start_i && (bit_q != 6'd0);
  assign chunk_a    = bump_start ? pgu_pkg::chunk_step(chunk_q) : chunk_q;
  assign bit_a      = bump_start ? 6'd0 : bit_q;
  assign bit_inc    = {1'b0, bit_a} + 7'd1;

  // decode the four pairs of the byte
  always_comb begin
    add_allele = 4'd0;
    add_called = 3'd0;
    for (int k = 0; k < 4; k++) begin
      batch.geno_mask[k] = !skip_now && ({byte_pos_q, 2'(k)} < samples_q);
      if (format_q) begin
        batch.geno[k] = pgu_pkg::remap_code(packed_byte_i[2*k +: 2]);
      end else begin
        batch.geno[k] = packed_byte_i[6-2*k +: 2];
      end
      if (batch.geno_mask[k] && (batch.geno[k] != pgu_pkg::GENO_MISSING)) begin
        add_allele = add_allele + {2'd0, batch.geno[k]};
        add_called = add_called + 3'd1;
      end
    end
    allele_new        = allele_q + {13'd0, add_allele};
    called_new        = called_q + {13'd0, add_called};
    batch.summary     = !skip_now && end_rec;
    batch.sample_base = {byte_pos_q, 2'b00};
    batch.chunk       = chunk_a;
    batch.bit_idx     = bit_a;
    batch.allele      = allele_new;
    batch.called      = called_new;
  end

  assign batch_load = accept && ((batch.geno_mask != 4'd0) || batch.summary);

  // locus and record state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= 14'd0;
      chunk_q    <= 16'd0;
      bit_q      <= 6'd0;
      allele_q   <= 17'd0;
      called_q   <= 16'd0;
      skipping_q <= 1'b0;
    end else if (accept) begin
      skipping_q <= skip_now;
      if (end_rec) begin
        byte_pos_q <= 14'd0;
        allele_q   <= 17'd0;
        called_q   <= 16'd0;
        if (!skip_now && (bit_inc >= ChunkBitsW)) begin
          chunk_q <= pgu_pkg::chunk_step(chunk_a);
          bit_q   <= 6'd0;
        end else if (!skip_now) begin
          chunk_q <= chunk_a;
          bit_q   <= bit_inc[5:0];
        end else begin
          chunk_q <= chunk_a;
          bit_q   <= bit_a;
        end
      end else begin
        byte_pos_q <= byte_pos_q + 14'd1;
        allele_q   <= allele_new;
        called_q   <= called_new;
        chunk_q    <= chunk_a;
        bit_q      <= bit_a;
      end
    end
  end

  // result sequencing
  pgu_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (batch_load),
    .batch_i     (batch),
    .take_o      (take),
    .result_o    (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  assign in_ready_o     = take;
  assign result_kind_o  = res.kind;
  assign sample_index_o = res.sample;
  assign chunk_index_o  = res.chunk;
  assign bit_index_o    = res.bit_idx;
  assign genotype_o     = res.geno;
  assign allele_count_o = res.allele;
  assign called_count_o = res.called;
  assign last_o         = res.last;

  // checks
  `PGU_ASSERT_NOW(a_bit_in_chunk, 1'b1, {1'b0, bit_q} < ChunkBitsW, "bit index past chunk size")
  `PGU_ASSERT_NOW(a_summary_clean, out_valid_o && result_kind_o, (sample_index_o == 16'd0) && (genotype_o == 2'd0), "summary carries genotype fields")
  `PGU_ASSERT_NEXT(a_record_wraps, accept && end_rec, byte_pos_q == 14'd0, "record end did not rewind position")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int LOCI_PER_CHUNK = 64;
  localparam int IDLE_PCT       = 19;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int MAX_REPORTS    = 40;
  localparam int N_PHASES       = 7;

  localparam logic FMT_MSB_PASS  = 1'b0;
  localparam logic FMT_LSB_REMAP = 1'b1;
  localparam logic KIND_GENO     = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  // genotype of each raw pair in the lsb-first format
  localparam logic [1:0] LSB_FIRST_CODE [4] = '{2'd2, pgu_pkg::GENO_MISSING, 2'd1, 2'd0};

  // one step of the directed part: a register write or one record byte
  typedef struct packed {
    logic              is_reg;
    pgu_pkg::reg_idx_e idx;
    logic [31:0]       value;
    logic [7:0]        pb;
    logic              skip;
    logic              chrom;
    logic              typed;
    logic [1:0]        geno0;
    logic [16:0]       ac;
    logic [15:0]       cc;
  } step_t;

  localparam int N_DIRECTED = 29;

  // typed rows give the first genotype and the summary counts
  //    reg   index                 value      byte   skip  chrom typed geno0 allele called
  step_t directed_steps [N_DIRECTED] = '{
    // reset settings: lsb-first remap, one sample, one-byte records
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'h00, 1'b0, 1'b0, 1'b1, 2'd2, 17'd2, 16'd1},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'hFD, 1'b0, 1'b0, 1'b1, 2'd3, 17'd0, 16'd0},
    // chromosome start with a nonzero locus moves the chunk on
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'hFF, 1'b0, 1'b1, 1'b1, 2'd0, 17'd0, 16'd1},
    '{1'b1, pgu_pkg::REG_FORMAT,  32'd0,     8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b1, pgu_pkg::REG_SAMPLES, 32'd4,     8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'h1B, 1'b0, 1'b0, 1'b1, 2'd0, 17'd3, 16'd3},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'hE4, 1'b0, 1'b1, 1'b0, 2'd0, 17'd0, 16'd0},
    // six samples in three bytes: padding pairs and a padding byte
    '{1'b1, pgu_pkg::REG_SAMPLES, 32'd6,     8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b1, pgu_pkg::REG_BYTES,   32'd3,     8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    // skipped marker, its chromosome start ignored
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'hFF, 1'b1, 1'b1, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'h55, 1'b1, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'h27, 1'b0, 1'b1, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'h9C, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'hFF, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    // zero record length acts as one, samples beyond the record
    '{1'b1, pgu_pkg::REG_BYTES,   32'd0,     8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b1, pgu_pkg::REG_SAMPLES, 32'd65535, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'hFF, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'h00, 1'b0, 1'b1, 1'b0, 2'd0, 17'd0, 16'd0},
    // oversized record length, then lowered mid-record
    '{1'b1, pgu_pkg::REG_BYTES,   32'd32767, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b1, pgu_pkg::REG_FORMAT,  32'd1,     8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b1, pgu_pkg::REG_SAMPLES, 32'd9,     8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'h12, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'h34, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'h56, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b1, pgu_pkg::REG_BYTES,   32'd2,     8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'h78, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    // no samples at all: summaries only, with zero counts
    '{1'b1, pgu_pkg::REG_SAMPLES, 32'd0,     8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0},
    '{1'b0, pgu_pkg::REG_NONE,    32'd0,     8'hAB, 1'b0, 1'b0, 1'b0, 2'd0, 17'd0, 16'd0}
  };

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        psel               = 1'b0;
  logic        penable            = 1'b0;
  logic        pwrite             = 1'b0;
  logic [3:0]  paddr              = '0;
  logic [31:0] pwdata             = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i         = 1'b0;
  logic        in_ready_o;
  logic [7:0]  packed_byte_i      = '0;
  logic        skip_marker_i      = 1'b0;
  logic        chromosome_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i        = 1'b0;
  logic        result_kind_o;
  logic [15:0] sample_index_o;
  logic [15:0] chunk_index_o;
  logic [5:0]  bit_index_o;
  logic [1:0]  genotype_o;
  logic [16:0] allele_count_o;
  logic [15:0] called_count_o;
  logic        last_o;

  packed_genotype_unpacker #(
    .CHUNK_BITS(LOCI_PER_CHUNK)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .packed_byte_i     (packed_byte_i),
    .skip_marker_i     (skip_marker_i),
    .chromosome_start_i(chromosome_start_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_kind_o     (result_kind_o),
    .sample_index_o    (sample_index_o),
    .chunk_index_o     (chunk_index_o),
    .bit_index_o       (bit_index_o),
    .genotype_o        (genotype_o),
    .allele_count_o    (allele_count_o),
    .called_count_o    (called_count_o),
    .last_o            (last_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // decoder settings and state as the block should hold them
  logic        cfg_format    = FMT_LSB_REMAP;
  logic [15:0] cfg_samples   = 16'd1;
  logic [14:0] cfg_rec_bytes = 15'd1;
  logic [13:0] byte_pos      = '0;
  logic [15:0] chunk_now     = '0;
  logic [5:0]  locus_bit     = '0;
  logic [16:0] allele_acc    = '0;
  logic [15:0] called_acc    = '0;
  logic        skip_rec      = 1'b0;

  pgu_pkg::result_t byte_words[$];
  pgu_pkg::result_t expected_words[$];
  bit          idle_en      = 1'b1;
  int unsigned n_errors     = 0;
  int unsigned n_bytes      = 0;
  int unsigned n_words      = 0;
  int unsigned cycle_count  = 0;

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // record length after clamping to the legal range
  function automatic int unsigned rec_span();
    if (cfg_rec_bytes == 0)
      return 1;
    if (cfg_rec_bytes > pgu_pkg::MAX_REC_BYTES)
      return 32'(pgu_pkg::MAX_REC_BYTES);
    return 32'(cfg_rec_bytes);
  endfunction

  function automatic void next_chunk();
    if (chunk_now != pgu_pkg::CHUNK_MAX)
      chunk_now++;
    locus_bit = '0;
  endfunction

  // words one accepted byte gives, left in byte_words
  task automatic unpack_byte(input logic [7:0] pb, input logic skip, input logic chrom);
    logic             rec_end;
    int unsigned      smp;
    logic [1:0]       g;
    pgu_pkg::result_t w;
    rec_end = (byte_pos >= rec_span() - 1);
    byte_words.delete();
    // marker flags count on the first byte only
    if (byte_pos == 0) begin
      skip_rec = skip;
      if (!skip_rec && chrom && locus_bit != 0)
        next_chunk();
    end
    if (!skip_rec) begin
      for (int k = 0; k < 4; k++) begin
        smp = byte_pos * 4 + k;
        if (smp >= cfg_samples)
          break;
        if (cfg_format == FMT_MSB_PASS)
          g = pb[(7 - 2 * k) -: 2];
        else
          g = LSB_FIRST_CODE[pb[2 * k +: 2]];
        if (g != pgu_pkg::GENO_MISSING) begin
          allele_acc = allele_acc + 17'(g);
          called_acc = called_acc + 16'd1;
        end
        w = '0;
        w.kind = KIND_GENO;
        w.sample = smp[15:0];
        w.chunk = chunk_now;
        w.bit_idx = locus_bit;
        w.geno = g;
        byte_words.push_back(w);
      end
      if (rec_end) begin
        w = '0;
        w.kind = KIND_SUMMARY;
        w.chunk = chunk_now;
        w.bit_idx = locus_bit;
        w.allele = allele_acc;
        w.called = called_acc;
        byte_words.push_back(w);
      end
      if (byte_words.size() > 0)
        byte_words[byte_words.size() - 1].last = 1'b1;
    end
    // locus advance at the record end
    if (rec_end) begin
      if (!skip_rec) begin
        if (int'(locus_bit) + 1 >= LOCI_PER_CHUNK)
          next_chunk();
        else
          locus_bit++;
      end
      allele_acc = '0;
      called_acc = '0;
      byte_pos = '0;
    end else begin
      byte_pos++;
    end
  endtask

  // send one byte, queue what it should give
  task automatic send_byte(input step_t s);
    if (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (idle_en && $urandom_range(99) < IDLE_PCT);
    end
    in_valid_i <= 1'b1;
    packed_byte_i <= s.pb;
    skip_marker_i <= s.skip;
    chromosome_start_i <= s.chrom;
    do @(posedge clk_i); while (!in_ready_o);
    n_bytes++;
    unpack_byte(s.pb, s.skip, s.chrom);
    foreach (byte_words[i]) begin
      if (s.typed && i == 0 && byte_words[i].kind == KIND_GENO)
        byte_words[i].geno = s.geno0;
      if (s.typed && byte_words[i].kind == KIND_SUMMARY) begin
        byte_words[i].allele = s.ac;
        byte_words[i].called = s.cc;
      end
      expected_words.push_back(byte_words[i]);
    end
  endtask

  // let the block drain before touching its registers
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, then read back
  task automatic reg_write(input pgu_pkg::reg_idx_e idx, input logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      pgu_pkg::REG_FORMAT:  mask = 32'h1;
      pgu_pkg::REG_SAMPLES: mask = 32'hFFFF;
      default:              mask = 32'h7FFF;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      pgu_pkg::REG_FORMAT:  cfg_format = value[0];
      pgu_pkg::REG_SAMPLES: cfg_samples = value[15:0];
      default:              cfg_rec_bytes = value[14:0];
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    compare_field("prdata", value & mask, prdata & mask);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver stalls
  always @(posedge clk_i)
    out_ready_i <= !idle_en || ($urandom_range(99) >= IDLE_PCT);

  // result word check against the oldest expectation
  always @(posedge clk_i) begin
    pgu_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $error("result word with nothing expected: kind %0d sample %0d",
                 result_kind_o, sample_index_o);
      end else begin
        want = expected_words.pop_front();
        n_words++;
        compare_field("result_kind", 32'(want.kind), 32'(result_kind_o));
        compare_field("sample_index", 32'(want.sample), 32'(sample_index_o));
        compare_field("chunk_index", 32'(want.chunk), 32'(chunk_index_o));
        compare_field("bit_index", 32'(want.bit_idx), 32'(bit_index_o));
        compare_field("genotype", 32'(want.geno), 32'(genotype_o));
        compare_field("allele_count", 32'(want.allele), 32'(allele_count_o));
        compare_field("called_count", 32'(want.called), 32'(called_count_o));
        compare_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    step_t       st;
    int unsigned pick;
    int unsigned span;
    int unsigned sent;
    logic [31:0] n_smp;
    logic [31:0] n_rec;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_reg) begin
        settle();
        reg_write(directed_steps[i].idx, directed_steps[i].value);
      end else begin
        send_byte(directed_steps[i]);
      end
    end
    // closing byte of the zero-sample record, counts typed
    st = '0;
    st.pb = 8'hCD;
    st.typed = 1'b1;
    send_byte(st);

    // random phases of whole records, one of them without stalls
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      idle_en = (ph != 3);
      pick = $urandom_range(5, 0);
      case (pick)
        0: begin
          n_smp = 0;
          n_rec = $urandom_range(3, 1);
        end
        1: begin
          n_smp = 65535;
          n_rec = $urandom_range(3, 1);
        end
        2: begin
          n_smp = $urandom_range(4, 1);
          n_rec = 0;
        end
        default: begin
          n_smp = $urandom_range(12, 1);
          n_rec = (n_smp + 3) / 4 + $urandom_range(1);
        end
      endcase
      reg_write(pgu_pkg::REG_FORMAT, $urandom_range(1));
      reg_write(pgu_pkg::REG_SAMPLES, n_smp);
      reg_write(pgu_pkg::REG_BYTES, n_rec);
      span = rec_span();
      sent = 0;
      while (sent < 16) begin
        for (int b = 0; b < span; b++) begin
          st = '0;
          st.pb = 8'($urandom);
          st.skip = (b == 0) ? ($urandom_range(99) < 15) : 1'($urandom_range(1));
          st.chrom = (b == 0) ? ($urandom_range(99) < 30) : 1'($urandom_range(1));
          send_byte(st);
        end
        sent += span;
      end
    end
    idle_en = 1'b1;

    // drain
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d bytes and %0d result words: both formats, skipped markers,",
             n_bytes, n_words);
    $display("padding, clamped and lowered record lengths, zero-sample records");
    if (n_errors == 0 && expected_words.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
